[hw/rtl/jsu_pkg.sv]
`default_nettype none

package jsu_pkg;

    localparam int QueueDepthDefault = 4;

    // What follows the code points of one command.
    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_DATA = 2'd1;
    localparam logic [1:0] TAIL_DONE = 2'd2;
    localparam logic [1:0] TAIL_ERR  = 2'd3;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [2:0] ERR_NO_QUOTE     = 3'd0;
    localparam logic [2:0] ERR_TRUNC_ESC    = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX      = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN_ESC  = 3'd3;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd4;

    // One command holds every result of one input item: up to two code
    // points sent as UTF-8, then an optional raw byte, finish or error.
    typedef struct packed {
        logic        a_valid;
        logic [20:0] a_cp;
        logic        b_valid;
        logic [15:0] b_cp;
        logic [1:0]  tail;
        logic [7:0]  tail_byte;
        logic [2:0]  tail_code;
    } cmd_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] code;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/jsu_front.sv]
`default_nettype none

module jsu_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [7:0]   in_byte,
    input  wire logic         end_of_text,
    input  wire logic         accept,
    output jsu_pkg::cmd_t     cmd,
    output logic              push
);
    import jsu_pkg::*;

    localparam logic [2:0] PH_WAIT     = 3'd0;
    localparam logic [2:0] PH_STR      = 3'd1;
    localparam logic [2:0] PH_ESC      = 3'd2;
    localparam logic [2:0] PH_HEX      = 3'd3;
    localparam logic [2:0] PH_HIGH     = 3'd4;
    localparam logic [2:0] PH_HIGH_BSL = 3'd5;
    localparam logic [2:0] PH_LOW_HEX  = 3'd6;
    localparam logic [2:0] PH_DONE     = 3'd7;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [15:0] hex_accum_reg;
    logic [15:0] hex_accum_next;
    logic [1:0]  hex_seen_reg;
    logic [1:0]  hex_seen_next;
    logic [15:0] pending_reg;
    logic [15:0] pending_next;

    logic        hex_ok;
    logic [3:0]  hex_d;
    logic [15:0] unit;
    logic        fourth;
    logic        unit_high;
    logic        unit_low;

    logic [1:0]  str_tail;
    logic [2:0]  str_phase;
    logic [1:0]  esc_tail;
    logic [7:0]  esc_byte;
    logic [2:0]  esc_phase;

    always_comb
    begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            hex_d = in_byte[3:0];
        end
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) || (in_byte >= 8'h41 && in_byte <= 8'h46))
        begin
            hex_d = in_byte[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign unit      = {hex_accum_reg[11:0], hex_d};
    assign fourth    = (hex_seen_reg == 2'd3);
    assign unit_high = (unit[15:10] == 6'b110110);
    assign unit_low  = (unit[15:10] == 6'b110111);

    always_comb
    begin
        if (in_byte == CH_QUOTE)
        begin
            str_tail  = TAIL_DONE;
            str_phase = PH_DONE;
        end
        else if (in_byte == CH_BSL)
        begin
            str_tail  = TAIL_NONE;
            str_phase = PH_ESC;
        end
        else
        begin
            str_tail  = TAIL_DATA;
            str_phase = PH_STR;
        end
    end

    always_comb
    begin
        esc_tail  = TAIL_DATA;
        esc_phase = PH_STR;
        esc_byte  = in_byte;
        case (in_byte)
            CH_QUOTE: esc_byte = CH_QUOTE;
            CH_BSL:   esc_byte = CH_BSL;
            CH_SLASH: esc_byte = CH_SLASH;
            CH_B:     esc_byte = 8'h08;
            CH_F:     esc_byte = 8'h0C;
            CH_N:     esc_byte = 8'h0A;
            CH_R:     esc_byte = 8'h0D;
            CH_T:     esc_byte = 8'h09;
            CH_U:
            begin
                esc_tail  = TAIL_NONE;
                esc_phase = PH_HEX;
            end
            default:
            begin
                esc_tail  = TAIL_ERR;
                esc_phase = PH_DONE;
            end
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        hex_accum_next = hex_accum_reg;
        hex_seen_next  = hex_seen_reg;
        pending_next   = pending_reg;
        cmd            = '0;

        if (accept && end_of_text)
        begin
            cmd.tail       = TAIL_ERR;
            phase_next     = PH_WAIT;
            hex_accum_next = '0;
            hex_seen_next  = '0;
            cmd.a_cp       = {5'd0, pending_reg};
            case (phase_reg)
                PH_WAIT:     cmd.tail_code = ERR_NO_QUOTE;
                PH_STR:      cmd.tail_code = ERR_UNTERMINATED;
                PH_ESC:      cmd.tail_code = ERR_TRUNC_ESC;
                PH_HEX:      cmd.tail_code = ERR_BAD_HEX;
                PH_HIGH:
                begin
                    cmd.a_valid   = 1'b1;
                    cmd.tail_code = ERR_UNTERMINATED;
                end
                PH_HIGH_BSL:
                begin
                    cmd.a_valid   = 1'b1;
                    cmd.tail_code = ERR_TRUNC_ESC;
                end
                PH_LOW_HEX:
                begin
                    cmd.a_valid   = 1'b1;
                    cmd.tail_code = ERR_BAD_HEX;
                end
                default:     cmd.tail = TAIL_NONE;
            endcase
        end
        else if (accept)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        phase_next = PH_STR;
                    end
                    else
                    begin
                        cmd.tail      = TAIL_ERR;
                        cmd.tail_code = ERR_NO_QUOTE;
                        phase_next    = PH_DONE;
                    end
                end
                PH_STR:
                begin
                    cmd.tail      = str_tail;
                    cmd.tail_byte = (str_tail == TAIL_DATA) ? in_byte : 8'd0;
                    phase_next    = str_phase;
                end
                PH_ESC:
                begin
                    cmd.tail      = esc_tail;
                    cmd.tail_byte = (esc_tail == TAIL_DATA) ? esc_byte : 8'd0;
                    cmd.tail_code = (esc_tail == TAIL_ERR) ? ERR_UNKNOWN_ESC : ERR_NO_QUOTE;
                    phase_next    = esc_phase;
                    if (esc_phase == PH_HEX)
                    begin
                        hex_accum_next = '0;
                        hex_seen_next  = '0;
                    end
                end
                PH_HEX:
                begin
                    if (!hex_ok)
                    begin
                        cmd.tail      = TAIL_ERR;
                        cmd.tail_code = ERR_BAD_HEX;
                        phase_next    = PH_DONE;
                    end
                    else
                    begin
                        hex_accum_next = unit;
                        hex_seen_next  = hex_seen_reg + 2'd1;
                        if (fourth)
                        begin
                            if (unit_high)
                            begin
                                pending_next = unit;
                                phase_next   = PH_HIGH;
                            end
                            else
                            begin
                                cmd.a_valid = 1'b1;
                                cmd.a_cp    = {5'd0, unit};
                                phase_next  = PH_STR;
                            end
                        end
                    end
                end
                PH_HIGH:
                begin
                    if (in_byte == CH_BSL)
                    begin
                        phase_next = PH_HIGH_BSL;
                    end
                    else
                    begin
                        cmd.a_valid   = 1'b1;
                        cmd.a_cp      = {5'd0, pending_reg};
                        cmd.tail      = str_tail;
                        cmd.tail_byte = (str_tail == TAIL_DATA) ? in_byte : 8'd0;
                        phase_next    = str_phase;
                    end
                end
                PH_HIGH_BSL:
                begin
                    if (in_byte == CH_U)
                    begin
                        hex_accum_next = '0;
                        hex_seen_next  = '0;
                        phase_next     = PH_LOW_HEX;
                    end
                    else
                    begin
                        cmd.a_valid   = 1'b1;
                        cmd.a_cp      = {5'd0, pending_reg};
                        cmd.tail      = esc_tail;
                        cmd.tail_byte = (esc_tail == TAIL_DATA) ? esc_byte : 8'd0;
                        cmd.tail_code = (esc_tail == TAIL_ERR) ? ERR_UNKNOWN_ESC : ERR_NO_QUOTE;
                        phase_next    = esc_phase;
                    end
                end
                PH_LOW_HEX:
                begin
                    if (!hex_ok)
                    begin
                        cmd.a_valid   = 1'b1;
                        cmd.a_cp      = {5'd0, pending_reg};
                        cmd.tail      = TAIL_ERR;
                        cmd.tail_code = ERR_BAD_HEX;
                        phase_next    = PH_DONE;
                    end
                    else
                    begin
                        hex_accum_next = unit;
                        hex_seen_next  = hex_seen_reg + 2'd1;
                        if (fourth)
                        begin
                            cmd.a_valid = 1'b1;
                            if (unit_low)
                            begin
                                cmd.a_cp   = 21'h10000 + {1'b0, pending_reg[9:0], unit[9:0]};
                                phase_next = PH_STR;
                            end
                            else
                            begin
                                cmd.a_cp = {5'd0, pending_reg};
                                if (unit_high)
                                begin
                                    pending_next = unit;
                                    phase_next   = PH_HIGH;
                                end
                                else
                                begin
                                    cmd.b_valid = 1'b1;
                                    cmd.b_cp    = unit;
                                    phase_next  = PH_STR;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    assign push = accept && (cmd.a_valid || cmd.b_valid || cmd.tail != TAIL_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            hex_accum_reg <= '0;
            hex_seen_reg  <= '0;
            pending_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hex_accum_reg <= hex_accum_next;
            hex_seen_reg  <= hex_seen_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/jsu_queue.sv]
`default_nettype none

module jsu_queue #(
    parameter int Depth = jsu_pkg::QueueDepthDefault
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire jsu_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output jsu_pkg::cmd_t      head,
    output logic               empty
);
    import jsu_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    cmd_t            entries_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full  = (count_reg == CntW'(Depth));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/jsu_back.sv]
`default_nettype none

module jsu_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire jsu_pkg::cmd_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [15:0]        m_axis_tdata,
    output logic [1:0]         m_axis_tuser,
    output logic               m_axis_tlast
);
    import jsu_pkg::*;

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp < 21'h80)
        begin
            len = 3'd1;
        end
        else if (cp < 21'h800)
        begin
            len = 3'd2;
        end
        else if (cp < 21'h10000)
        begin
            len = 3'd3;
        end
        else
        begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                             input logic [1:0] k);
        logic [7:0] b;
        b = 8'h80 | {2'b00, cp[5:0]};
        case (len)
            3'd1: b = cp[7:0];
            3'd2:
            begin
                if (k == 2'd0)
                begin
                    b = 8'hC0 | {3'b000, cp[10:6]};
                end
            end
            3'd3:
            begin
                if (k == 2'd0)
                begin
                    b = 8'hE0 | {4'b0000, cp[15:12]};
                end
                else if (k == 2'd1)
                begin
                    b = 8'h80 | {2'b00, cp[11:6]};
                end
            end
            default:
            begin
                if (k == 2'd0)
                begin
                    b = 8'hF0 | {5'b00000, cp[20:18]};
                end
                else if (k == 2'd1)
                begin
                    b = 8'h80 | {2'b00, cp[17:12]};
                end
                else if (k == 2'd2)
                begin
                    b = 8'h80 | {2'b00, cp[11:6]};
                end
            end
        endcase
        return b;
    endfunction

    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic        valid_reg;
    logic        valid_next;
    result_t     res_reg;
    logic        last_reg;

    logic [2:0]  len_a;
    logic [2:0]  len_b;
    logic [3:0]  len_ab;
    logic [3:0]  total;
    logic [3:0]  idx_wide;
    logic [3:0]  idx_b;
    logic        is_last;
    logic        out_free;
    logic        emit;
    result_t     entry;

    assign len_a    = head.a_valid ? utf8_len(head.a_cp) : 3'd0;
    assign len_b    = head.b_valid ? utf8_len({5'd0, head.b_cp}) : 3'd0;
    assign len_ab   = {1'b0, len_a} + {1'b0, len_b};
    assign total    = len_ab + {3'd0, head.tail != TAIL_NONE};
    assign idx_wide = {1'b0, idx_reg};
    assign idx_b    = idx_wide - {1'b0, len_a};
    assign is_last  = (idx_wide + 4'd1 == total);

    always_comb
    begin
        entry = '0;
        if (idx_wide < {1'b0, len_a})
        begin
            entry.data = utf8_byte(head.a_cp, len_a, idx_reg[1:0]);
            entry.kind = KIND_DATA;
        end
        else if (idx_wide < len_ab)
        begin
            entry.data = utf8_byte({5'd0, head.b_cp}, len_b, idx_b[1:0]);
            entry.kind = KIND_DATA;
        end
        else
        begin
            case (head.tail)
                TAIL_DATA:
                begin
                    entry.data = head.tail_byte;
                    entry.kind = KIND_DATA;
                end
                TAIL_DONE:
                begin
                    entry.kind = KIND_DONE;
                end
                TAIL_ERR:
                begin
                    entry.kind = KIND_ERR;
                    entry.code = head.tail_code;
                end
                default:
                begin
                    entry.kind = KIND_DATA;
                end
            endcase
        end
    end

    assign out_free = !valid_reg || m_axis_tready;
    assign emit     = out_free && !empty;
    assign pop      = emit && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg  <= entry;
            last_reg <= is_last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {5'd0, res_reg.code, res_reg.data};
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire

[hw/rtl/json_string_unescape_utf8.sv]
// Channel   Direction  Fields (tdata / tuser / tlast)
// s_axis    in         tdata[7:0] in_byte; tuser end_of_text
// m_axis    out        tdata[7:0] out_byte, tdata[10:8] error_code;
//                      tuser[1:0] out_kind; tlast last
//
// Items with at most one result flow at one item per cycle while m_axis is ready.
// An item with several results stays at the queue head, sending one result at a time.
// The command queue of QueueDepth entries lets input keep flowing meanwhile.
// Reset clears the decoder state, the queue and the output valid flag.
// A stall on m_axis holds the output register; s_axis stalls only when the queue is full.
`default_nettype none

module json_string_unescape_utf8 #(
    parameter int QueueDepth = jsu_pkg::QueueDepthDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tuser,   // [0] end_of_text
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] error_code
    output logic [1:0]       m_axis_tuser,   // [1:0] out_kind
    output logic             m_axis_tlast
);
    import jsu_pkg::*;

    logic accept;
    logic push;
    logic full;
    logic pop;
    logic empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    jsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (s_axis_tdata),
        .end_of_text (s_axis_tuser),
        .accept      (accept),
        .cmd         (push_cmd),
        .push        (push)
    );

    jsu_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (pop),
        .head      (head_cmd),
        .empty     (empty)
    );

    jsu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head_cmd),
        .empty         (empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A finish or an error is always the final result of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_DONE || m_axis_tuser == KIND_ERR)
        |-> m_axis_tlast)
        else $error("finish or error result not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata[7:0] == 8'd0)
        else $error("nonzero byte on a non-data result");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_ERR |-> m_axis_tdata[10:8] == ERR_NO_QUOTE)
        else $error("error code set on a non-error result");

    // A command is popped only while the queue holds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command popped from an empty queue");

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;

    import jsu_pkg::*;

    localparam logic [2:0] NO_CODE = 3'd0;
    localparam int ItemTarget = 260;

    typedef enum logic [2:0] {
        ST_SEEK,
        ST_STRING,
        ST_ESCAPE,
        ST_HEX,
        ST_HIGH,
        ST_HIGH_BSL,
        ST_LOW_HEX,
        ST_CLOSED
    } dec_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] code;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eot;
        logic       typed;
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] code;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Decoder state as the predictor sees it.
    dec_state_t  dec_state = ST_SEEK;
    logic [15:0] dec_acc = 16'h0000;
    logic [1:0]  dec_ndig = 2'd0;
    logic [15:0] dec_high = 16'h0000;

    out_item_t   step_res[$];
    out_item_t   predicted_out_q[$];
    stim_row_t   dir_rows[$];
    logic [7:0]  text_q[$];

    bit          no_idle = 1'b0;
    int          sink_wait = 0;
    int          n_fail = 0;
    int          n_items = 0;
    int          n_live = 0;
    int          n_texts = 0;
    int          n_results = 0;
    int          n_data = 0;
    int          n_done = 0;
    int          n_err = 0;

    json_string_unescape_utf8 i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("json_string_unescape_utf8 verification failed");
        $finish;
    end

    function automatic void emit_res(logic [7:0] d, logic [1:0] k, logic [2:0] c);
        out_item_t r;
        r.data = d;
        r.kind = k;
        r.code = c;
        r.last = 1'b0;
        step_res.insert(step_res.size(), r);
    endfunction

    function automatic void fail_with(logic [2:0] c);
        emit_res(8'h00, KIND_ERR, c);
        dec_state = ST_CLOSED;
    endfunction

    function automatic void put_utf8(logic [20:0] cp);
        if (cp < 21'h80)
        begin
            emit_res(cp[7:0], KIND_DATA, NO_CODE);
        end
        else if (cp < 21'h800)
        begin
            emit_res({3'b110, cp[10:6]}, KIND_DATA, NO_CODE);
            emit_res({2'b10, cp[5:0]}, KIND_DATA, NO_CODE);
        end
        else if (cp < 21'h10000)
        begin
            emit_res({4'b1110, cp[15:12]}, KIND_DATA, NO_CODE);
            emit_res({2'b10, cp[11:6]}, KIND_DATA, NO_CODE);
            emit_res({2'b10, cp[5:0]}, KIND_DATA, NO_CODE);
        end
        else
        begin
            emit_res({5'b11110, cp[20:18]}, KIND_DATA, NO_CODE);
            emit_res({2'b10, cp[17:12]}, KIND_DATA, NO_CODE);
            emit_res({2'b10, cp[11:6]}, KIND_DATA, NO_CODE);
            emit_res({2'b10, cp[5:0]}, KIND_DATA, NO_CODE);
        end
    endfunction

    function automatic int hex_val(logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic void string_char(logic [7:0] b);
        dec_state = ST_STRING;
        if (b == "\"")
        begin
            emit_res(8'h00, KIND_DONE, NO_CODE);
            dec_state = ST_CLOSED;
        end
        else if (b == "\\")
        begin
            dec_state = ST_ESCAPE;
        end
        else
        begin
            emit_res(b, KIND_DATA, NO_CODE);
        end
    endfunction

    function automatic void escape_char(logic [7:0] b);
        logic [7:0] v;
        dec_state = ST_STRING;
        case (b)
            "\"", "\\", "/": v = b;
            "b": v = 8'h08;
            "f": v = 8'h0C;
            "n": v = 8'h0A;
            "r": v = 8'h0D;
            "t": v = 8'h09;
            "u":
            begin
                dec_acc = 16'h0000;
                dec_ndig = 2'd0;
                dec_state = ST_HEX;
                return;
            end
            default:
            begin
                fail_with(ERR_UNKNOWN_ESC);
                return;
            end
        endcase
        emit_res(v, KIND_DATA, NO_CODE);
    endfunction

    function automatic void code_unit(logic [15:0] v);
        if (v >= 16'hD800 && v <= 16'hDBFF)
        begin
            dec_high = v;
            dec_state = ST_HIGH;
        end
        else
        begin
            put_utf8({5'b0, v});
            dec_state = ST_STRING;
        end
    endfunction

    function automatic bit take_digit(int d);
        dec_acc = {dec_acc[11:0], d[3:0]};
        if (dec_ndig == 2'd3)
        begin
            dec_ndig = 2'd0;
            return 1'b1;
        end
        dec_ndig = dec_ndig + 2'd1;
        return 1'b0;
    endfunction

    function automatic void predict_item(logic [7:0] b, logic eot);
        int d;
        out_item_t r;
        step_res.delete();
        if (eot)
        begin
            case (dec_state)
                ST_SEEK: fail_with(ERR_NO_QUOTE);
                ST_STRING: fail_with(ERR_UNTERMINATED);
                ST_ESCAPE: fail_with(ERR_TRUNC_ESC);
                ST_HEX: fail_with(ERR_BAD_HEX);
                ST_HIGH:
                begin
                    put_utf8({5'b0, dec_high});
                    fail_with(ERR_UNTERMINATED);
                end
                ST_HIGH_BSL:
                begin
                    put_utf8({5'b0, dec_high});
                    fail_with(ERR_TRUNC_ESC);
                end
                ST_LOW_HEX:
                begin
                    put_utf8({5'b0, dec_high});
                    fail_with(ERR_BAD_HEX);
                end
                default: ;
            endcase
            dec_state = ST_SEEK;
            dec_acc = 16'h0000;
            dec_ndig = 2'd0;
        end
        else
        begin
            case (dec_state)
                ST_SEEK:
                begin
                    if (b == "\"") dec_state = ST_STRING;
                    else fail_with(ERR_NO_QUOTE);
                end
                ST_STRING: string_char(b);
                ST_ESCAPE: escape_char(b);
                ST_HEX:
                begin
                    d = hex_val(b);
                    if (d < 0) fail_with(ERR_BAD_HEX);
                    else if (take_digit(d)) code_unit(dec_acc);
                end
                ST_HIGH:
                begin
                    if (b == "\\")
                    begin
                        dec_state = ST_HIGH_BSL;
                    end
                    else
                    begin
                        put_utf8({5'b0, dec_high});
                        string_char(b);
                    end
                end
                ST_HIGH_BSL:
                begin
                    if (b == "u")
                    begin
                        dec_acc = 16'h0000;
                        dec_ndig = 2'd0;
                        dec_state = ST_LOW_HEX;
                    end
                    else
                    begin
                        put_utf8({5'b0, dec_high});
                        escape_char(b);
                    end
                end
                ST_LOW_HEX:
                begin
                    d = hex_val(b);
                    if (d < 0)
                    begin
                        put_utf8({5'b0, dec_high});
                        fail_with(ERR_BAD_HEX);
                    end
                    else if (take_digit(d))
                    begin
                        if (dec_acc >= 16'hDC00 && dec_acc <= 16'hDFFF)
                        begin
                            put_utf8(21'h10000 + {1'b0, dec_high[9:0], dec_acc[9:0]});
                            dec_state = ST_STRING;
                        end
                        else
                        begin
                            put_utf8({5'b0, dec_high});
                            code_unit(dec_acc);
                        end
                    end
                end
                default: ;
            endcase
        end
        if (step_res.size() > 0)
        begin
            r = step_res.pop_back();
            r.last = 1'b1;
            step_res.insert(step_res.size(), r);
        end
    endfunction

    function automatic void add_row(logic [7:0] b, logic eot, logic typed, logic [1:0] kind,
                                    logic [7:0] data, logic [2:0] code);
        stim_row_t row;
        row.b = b;
        row.eot = eot;
        row.typed = typed;
        row.kind = kind;
        row.data = data;
        row.code = code;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void add_text(logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] d);
        if (d < 4'd10) return 8'h30 + d;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 8'd10;
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == "\"" || b == "\\");
        return b;
    endfunction

    function automatic logic [7:0] rand_escape();
        case ($urandom_range(0, 7))
            0: return "\"";
            1: return "\\";
            2: return "/";
            3: return "b";
            4: return "f";
            5: return "n";
            6: return "r";
            default: return "t";
        endcase
    endfunction

    function automatic logic [15:0] rand_unit();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hD7FF));
            3: return 16'($urandom_range(16'hE000, 16'hFFFF));
            default: return 16'($urandom_range(16'hDC00, 16'hDFFF));
        endcase
    endfunction

    task automatic push_u(logic [15:0] v);
        add_text("\\");
        add_text("u");
        for (int i = 3; i >= 0; i--)
        begin
            add_text(hex_char(v[i*4 +: 4]));
        end
    endtask

    task automatic add_token();
        case ($urandom_range(0, 10))
            5, 6:
            begin
                add_text("\\");
                add_text(rand_escape());
            end
            7, 8: push_u(rand_unit());
            9:
            begin
                push_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                push_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            10:
            begin
                push_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                case ($urandom_range(0, 3))
                    0: add_text(rand_plain());
                    1:
                    begin
                        add_text("\\");
                        add_text(rand_escape());
                    end
                    2: push_u(rand_unit());
                    default: push_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                endcase
            end
            default: add_text(rand_plain());
        endcase
    endtask

    // Most texts are well-formed strings; the rest are cut short, carry a bad
    // escape, or lack the opening quote.
    task automatic build_text();
        int mode;
        int sub;
        int cut;
        logic [7:0] b;
        text_q.delete();
        mode = $urandom_range(0, 9);
        if (mode == 9)
        begin
            do b = 8'($urandom_range(0, 255)); while (b == "\"");
            add_text(b);
            repeat ($urandom_range(0, 4)) add_text(8'($urandom_range(0, 255)));
            return;
        end
        add_text("\"");
        repeat ($urandom_range(0, 8)) add_token();
        if (mode == 8)
        begin
            sub = $urandom_range(0, 3);
            if (sub >= 2) push_u(16'($urandom_range(16'hD800, 16'hDBFF)));
            add_text("\\");
            if (sub % 2 == 0)
            begin
                do b = 8'($urandom_range(0, 255));
                while (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
                       b == "n" || b == "r" || b == "t" || b == "u");
                add_text(b);
            end
            else
            begin
                add_text("u");
                repeat ($urandom_range(0, 3)) add_text(hex_char(4'($urandom_range(0, 15))));
                do b = 8'($urandom_range(0, 255)); while (hex_val(b) >= 0);
                add_text(b);
            end
            repeat ($urandom_range(0, 3)) add_token();
        end
        add_text("\"");
        if (mode == 6 || mode == 7)
        begin
            cut = $urandom_range(0, text_q.size() - 1);
            while (text_q.size() > cut) text_q.delete(text_q.size() - 1);
        end
        else
        begin
            repeat ($urandom_range(0, 2)) add_text(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic drive_item(logic [7:0] b, logic eot, logic typed, out_item_t fixed);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= eot;
        do @(posedge clk); while (!s_axis_tready);
        n_items++;
        if (dec_state != ST_CLOSED) n_live++;
        predict_item(b, eot);
        if (typed)
        begin
            predicted_out_q.insert(predicted_out_q.size(), fixed);
        end
        else
        begin
            foreach (step_res[i]) predicted_out_q.insert(predicted_out_q.size(), step_res[i]);
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        int w;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results++;
                case (m_axis_tuser)
                    KIND_DATA: n_data++;
                    KIND_DONE: n_done++;
                    default: n_err++;
                endcase
                if (predicted_out_q.size() == 0)
                begin
                    if (n_fail < 10)
                        $display("Unexpected result: tdata %04h tuser %0d tlast %0d",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    n_fail++;
                end
                else
                begin
                    want = predicted_out_q.pop_front();
                    if (m_axis_tdata !== {5'b0, want.code, want.data} ||
                        m_axis_tuser !== want.kind || m_axis_tlast !== want.last)
                    begin
                        if (n_fail < 10)
                        begin
                            $write("Result %0d mismatch: expected data %02h kind %0d ",
                                   n_results, want.data, want.kind);
                            $write("code %0d last %0d, ", want.code, want.last);
                            $display("got tdata %04h kind %0d last %0d",
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
                        end
                        n_fail++;
                    end
                end
                w = no_idle ? 0 : $urandom_range(0, 4);
                if (w > 0)
                begin
                    m_axis_tready <= 1'b0;
                    sink_wait <= w;
                end
            end
            else if (!m_axis_tready)
            begin
                if (sink_wait <= 1) m_axis_tready <= 1'b1;
                sink_wait <= sink_wait - 1;
            end
        end
    end

    initial
    begin
        out_item_t fixed;
        out_item_t blank;
        blank = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(8'h00, 1'b1, 1'b1, KIND_ERR, 8'h00, ERR_NO_QUOTE);
        add_row("A", 1'b0, 1'b1, KIND_ERR, 8'h00, ERR_NO_QUOTE);
        add_row(8'hFF, 1'b1, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("\"", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row(8'h00, 1'b0, 1'b1, KIND_DATA, 8'h00, NO_CODE);
        add_row(8'hFF, 1'b0, 1'b1, KIND_DATA, 8'hFF, NO_CODE);
        add_row("\\", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("t", 1'b0, 1'b1, KIND_DATA, 8'h09, NO_CODE);
        add_row("\\", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("u", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("F", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("f", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("F", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("f", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("\\", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("q", 1'b0, 1'b1, KIND_ERR, 8'h00, ERR_UNKNOWN_ESC);
        add_row(8'h00, 1'b1, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("\"", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("\\", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row(8'h00, 1'b1, 1'b1, KIND_ERR, 8'h00, ERR_TRUNC_ESC);
        add_row("\"", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("\"", 1'b0, 1'b1, KIND_DONE, 8'h00, NO_CODE);
        add_row(8'h00, 1'b1, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("\"", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row(8'h00, 1'b1, 1'b1, KIND_ERR, 8'h00, ERR_UNTERMINATED);
        add_row("\"", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("\\", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("u", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("0", 1'b0, 1'b0, KIND_DATA, 8'h00, NO_CODE);
        add_row("g", 1'b0, 1'b1, KIND_ERR, 8'h00, ERR_BAD_HEX);
        add_row(8'h00, 1'b1, 1'b0, KIND_DATA, 8'h00, NO_CODE);

        foreach (dir_rows[i])
        begin
            fixed.data = dir_rows[i].data;
            fixed.kind = dir_rows[i].kind;
            fixed.code = dir_rows[i].code;
            fixed.last = 1'b1;
            drive_item(dir_rows[i].b, dir_rows[i].eot, dir_rows[i].typed, fixed);
        end

        n_live = 0;
        while (n_items < ItemTarget)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            build_text();
            n_texts++;
            foreach (text_q[i]) drive_item(text_q[i], 1'b0, 1'b0, blank);
            drive_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, blank);
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (predicted_out_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d items, %0d random texts with %0d items the decoder acted on.",
                 n_items, n_texts, n_live);
        $display("Received %0d results: %0d bytes, %0d finished strings, %0d errors.",
                 n_results, n_data, n_done, n_err);
        if (n_fail == 0 && predicted_out_q.size() == 0)
        begin
            $display("json_string_unescape_utf8 verification clean");
        end
        else
        begin
            $display("json_string_unescape_utf8 verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
